FILE: hw/rtl/rccm_pkg.sv
// rccm_pkg: shared types and constants of the relative-change convergence monitor.
// No dependencies; imported by relative_change_convergence_monitor.
`default_nettype none
package rccm_pkg;
    localparam int MAX_ELEMENTS = 4096;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LEN_W        = 13;
    localparam int SUM_W        = 46;

    localparam logic [1:0] REG_EPSILON       = 2'd0;
    localparam logic [1:0] REG_STREAK_NEEDED = 2'd1;
    localparam logic [1:0] REG_PASS_LIMIT    = 2'd2;
    localparam logic [1:0] REG_VECTOR_LENGTH = 2'd3;

    typedef struct packed {
        logic signed [31:0] sample_im;
        logic signed [31:0] sample_re;
    } sample_t;

    typedef struct packed {
        logic [31:0] error_ratio;
        logic        below_tolerance;
        logic        converged;
        logic        timed_out;
        logic [15:0] pass_number;
    } result_t;
endpackage
`default_nettype wire

FILE: hw/rtl/relative_change_convergence_monitor.sv
// Flow: an element keeps s_ready low through its steps (read, 2 x (2 square + 34 root steps));
// the result follows the last element's transaction through check, 32 divide steps and
// output (check straight to output when saturated), later while the previous result is waiting.
// A new element is taken only once the last one is through the shared root/divide unit; needs rccm_pkg.
// Reset: synchronous active-low aresetn clears control, counters and the fill count; the
// previous-pass memory is not swept, entries at or above the fill count read as zero.
`default_nettype none
module relative_change_convergence_monitor import rccm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sample_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output result_t          m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_SQA  = 4'd2;
    localparam logic [3:0] ST_SQB  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;

    // configuration registers
    logic [31:0]      epsilon_reg;
    logic [7:0]       streak_needed_reg;
    logic [15:0]      pass_limit_reg;
    logic [LEN_W-1:0] vector_length_reg;

    // control state
    logic [3:0]       state_reg;
    logic [LEN_W-1:0] stored_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [SUM_W-1:0] diff_sum_reg, mag_sum_reg;
    logic [15:0]      streak_reg, pass_reg;
    logic             second_reg;
    logic [5:0]       cnt_reg;

    // datapath
    sample_t          smp_reg;
    logic [63:0]      mem [MAX_ELEMENTS];
    logic [63:0]      mem_q;
    logic [32:0]      op_a_reg, op_b_reg, n_re_reg, n_im_reg;
    logic [65:0]      sqa_reg;
    logic [67:0]      rad_reg;
    logic [47:0]      rem_reg;
    logic [33:0]      root_reg;
    logic [31:0]      lo_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // length clamp at the first element of a pass
    logic [LEN_W-1:0] len_clamped;
    always_comb begin
        len_clamped = vector_length_reg;
        if (vector_length_reg == '0) begin
            len_clamped = LEN_W'(1);
        end else if (vector_length_reg > LEN_W'(MAX_ELEMENTS)) begin
            len_clamped = LEN_W'(MAX_ELEMENTS);
        end
    end

    // old value: entries not written since the last clear read as zero
    logic signed [32:0] old_re, old_im, new_re, new_im, d_re, d_im;
    always_comb begin
        if ({1'b0, pos_reg} < fill_reg) begin
            old_re = 33'(signed'(mem_q[31:0]));
            old_im = 33'(signed'(mem_q[63:32]));
        end else begin
            old_re = '0;
            old_im = '0;
        end
        new_re = 33'(smp_reg.sample_re);
        new_im = 33'(smp_reg.sample_im);
        d_re   = new_re - old_re;
        d_im   = new_im - old_im;
    end

    // shared multiplier and compare-subtract unit
    logic [32:0] mul_op;
    logic [65:0] mul_p;
    logic [47:0] sub_a, sub_b;
    logic [48:0] sub_d;
    logic        sub_ge;
    assign mul_op = (state_reg == ST_SQA) ? op_a_reg : op_b_reg;
    assign mul_p  = mul_op * mul_op;
    always_comb begin
        if (state_reg == ST_DIV) begin
            sub_a = {rem_reg[46:0], lo_reg[31]};
            sub_b = {2'b00, mag_sum_reg};
        end else begin
            sub_a = {rem_reg[45:0], rad_reg[67:66]};
            sub_b = {12'd0, root_reg, 2'b01};
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[48];
    end

    // end-of-pass figures
    logic [31:0] err;
    logic        below, tout, conv;
    logic [15:0] streak_next;
    always_comb begin
        err         = root_reg[31:0];
        below       = err < epsilon_reg;
        tout        = pass_reg >= pass_limit_reg;
        streak_next = below ? ((streak_reg == 16'hFFFF) ? streak_reg : streak_reg + 16'd1)
                            : 16'd0;
        conv        = (streak_next > {8'd0, streak_needed_reg}) || tout;
    end

    logic [LEN_W-1:0] pos_inc;
    assign pos_inc = {1'b0, pos_reg} + LEN_W'(1);

    // memory: registered read, write in the read-back cycle
    always_ff @(posedge aclk) begin
        mem_q <= mem[(state_reg == ST_IDLE) ? pos_reg : pos_reg];
        if (state_reg == ST_RD) begin
            mem[pos_reg] <= smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg       <= 32'd168;
            streak_needed_reg <= 8'd0;
            pass_limit_reg    <= 16'd100;
            vector_length_reg <= LEN_W'(MAX_ELEMENTS);
            state_reg         <= ST_IDLE;
            stored_len_reg    <= '0;
            fill_reg          <= '0;
            pos_reg           <= '0;
            diff_sum_reg      <= '0;
            mag_sum_reg       <= '0;
            streak_reg        <= '0;
            pass_reg          <= 16'd1;
            second_reg        <= 1'b0;
            cnt_reg           <= '0;
            m_valid           <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EPSILON:       epsilon_reg       <= cfg_data;
                    REG_STREAK_NEEDED: streak_needed_reg <= cfg_data[7:0];
                    REG_PASS_LIMIT:    pass_limit_reg    <= cfg_data[15:0];
                    REG_VECTOR_LENGTH: vector_length_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            // drop the taken transaction; the output state reloads it itself
            if (m_valid && m_ready && state_reg != ST_FIN) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        smp_reg <= s_data;
                        if (pos_reg == '0) begin
                            // latch the length; a new length clears the previous pass
                            if (len_clamped != stored_len_reg) begin
                                fill_reg <= '0;
                            end
                            stored_len_reg <= len_clamped;
                            diff_sum_reg   <= '0;
                            mag_sum_reg    <= '0;
                        end
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    op_a_reg   <= d_re[32] ? 33'(-d_re) : 33'(d_re);
                    op_b_reg   <= d_im[32] ? 33'(-d_im) : 33'(d_im);
                    n_re_reg   <= new_re[32] ? 33'(-new_re) : 33'(new_re);
                    n_im_reg   <= new_im[32] ? 33'(-new_im) : 33'(new_im);
                    if (pos_inc > fill_reg) begin
                        fill_reg <= pos_inc;
                    end
                    second_reg <= 1'b0;
                    state_reg  <= ST_SQA;
                end
                ST_SQA: begin
                    sqa_reg   <= mul_p;
                    state_reg <= ST_SQB;
                end
                ST_SQB: begin
                    rad_reg   <= 68'(sqa_reg) + 68'(mul_p);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= 6'd33;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    // one root bit per cycle
                    rad_reg  <= {rad_reg[65:0], 2'b00};
                    rem_reg  <= sub_ge ? sub_d[47:0] : sub_a;
                    root_reg <= {root_reg[32:0], sub_ge};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        if (!second_reg) begin
                            diff_sum_reg <= diff_sum_reg + SUM_W'({root_reg[32:0], sub_ge});
                            op_a_reg     <= n_re_reg;
                            op_b_reg     <= n_im_reg;
                            second_reg   <= 1'b1;
                            state_reg    <= ST_SQA;
                        end else begin
                            mag_sum_reg <= mag_sum_reg + SUM_W'({root_reg[32:0], sub_ge});
                            if (pos_inc < stored_len_reg) begin
                                pos_reg   <= pos_inc[IDX_W-1:0];
                                state_reg <= ST_IDLE;
                            end else begin
                                pos_reg   <= '0;
                                state_reg <= ST_CHK;
                            end
                        end
                    end
                end
                ST_CHK: begin
                    // zero denominator or quotient beyond 32 bits saturates
                    if (mag_sum_reg == '0 ||
                        {8'd0, diff_sum_reg} >= {mag_sum_reg, 8'd0}) begin
                        root_reg  <= {2'b00, 32'hFFFF_FFFF};
                        state_reg <= ST_FIN;
                    end else begin
                        rem_reg   <= 48'(diff_sum_reg[SUM_W-1:8]);
                        lo_reg    <= {diff_sum_reg[7:0], 24'd0};
                        root_reg  <= '0;
                        cnt_reg   <= 6'd31;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    lo_reg   <= {lo_reg[30:0], 1'b0};
                    rem_reg  <= sub_ge ? sub_d[47:0] : sub_a;
                    root_reg <= {root_reg[32:0], sub_ge};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // hold until the previous transaction has left
                    if (!m_valid || m_ready) begin
                        m_data.error_ratio     <= err;
                        m_data.below_tolerance <= below;
                        m_data.converged       <= conv;
                        m_data.timed_out       <= tout;
                        m_data.pass_number     <= pass_reg;
                        m_valid                <= 1'b1;
                        streak_reg             <= streak_next;
                        if (pass_reg != 16'hFFFF) begin
                            pass_reg <= pass_reg + 16'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_timeout_converges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.timed_out || m_data.converged))
        else $error("timed-out transaction not flagged converged");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= stored_len_reg)
        else $error("fill count beyond latched length");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while element in progress");
`endif
endmodule
`default_nettype wire
